### rtl/bsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared widths, register indexes and types of the box distance pipeline.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int DIMENSIONS_DEFAULT    = 3;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int COORD_W     = 32;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int CLAMP_W     = COORD_W - 1;
  localparam int SQ_W        = 2 * CLAMP_W;
  localparam int RES_W       = COORD_W + 2;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_LOW_X        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_X       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FLUID_INSIDE = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  // Per-item sideband that rides along the root pipeline.
  typedef struct packed {
    logic   any_pos;
    logic   too_long;
    delta_t largest;
  } side_t;

endpackage
`default_nettype wire

### rtl/bsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_front
// Four stages: axis deltas, clamp, squares and largest, sum of squares.
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; #(
  parameter  int DIMENSIONS = DIMENSIONS_DEFAULT,
  localparam int SUM_W      = SQ_W + $clog2(DIMENSIONS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire coord_t           point [DIMENSIONS],
  input  wire coord_t           low   [DIMENSIONS],
  input  wire coord_t           high  [DIMENSIONS],
  output logic                  valid,
  output logic [SUM_W-1:0]      sum,
  output side_t                 side
);

  logic s1_valid, s2_valid, s3_valid;

  delta_t             s1_a  [DIMENSIONS];
  delta_t             s1_b  [DIMENSIONS];
  delta_t             s2_d  [DIMENSIONS];
  logic [CLAMP_W-1:0] s2_dc [DIMENSIONS];
  logic [DIMENSIONS-1:0] s2_pos, s2_big;
  logic [SQ_W-1:0]    s3_sq [DIMENSIONS];
  side_t              s3_side;

  delta_t             d_next  [DIMENSIONS];
  logic [CLAMP_W-1:0] dc_next [DIMENSIONS];
  logic [DIMENSIONS-1:0] pos_next, big_next;
  delta_t             largest_next;
  logic [SUM_W-1:0]   sum_next;

  // Pick the larger delta per axis; clamp at zero, flag deltas of 2^31 or more.
  always_comb begin
    for (int i = 0; i < DIMENSIONS; i++) begin
      d_next[i]   = (s1_a[i] > s1_b[i]) ? s1_a[i] : s1_b[i];
      pos_next[i] = !d_next[i][DELTA_W-1] && (d_next[i] != '0);
      big_next[i] = !d_next[i][DELTA_W-1] && d_next[i][DELTA_W-2];
      dc_next[i]  = (pos_next[i] && !big_next[i]) ? d_next[i][CLAMP_W-1:0] : '0;
    end
  end

  always_comb begin
    largest_next = s2_d[0];
    for (int i = 1; i < DIMENSIONS; i++) begin
      if (s2_d[i] > largest_next) largest_next = s2_d[i];
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < DIMENSIONS; i++) sum_next = sum_next + SUM_W'(s3_sq[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      valid    <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        s1_a[i]  <= DELTA_W'(low[i]) - DELTA_W'(point[i]);
        s1_b[i]  <= DELTA_W'(point[i]) - DELTA_W'(high[i]);
        s2_d[i]  <= d_next[i];
        s2_dc[i] <= dc_next[i];
        s3_sq[i] <= SQ_W'(s2_dc[i]) * SQ_W'(s2_dc[i]);
      end
      s2_pos           <= pos_next;
      s2_big           <= big_next;
      s3_side.any_pos  <= |s2_pos;
      s3_side.too_long <= |s2_big;
      s3_side.largest  <= largest_next;
      sum              <= sum_next;
      side             <= s3_side;
    end
  end

endmodule
`default_nettype wire

### rtl/bsd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bsd_isqrt import bsd_pkg::*; #(
  parameter  int DIMENSIONS = DIMENSIONS_DEFAULT,
  localparam int SUM_W      = SQ_W + $clog2(DIMENSIONS),
  localparam int ROOT_W     = (SUM_W + 1) / 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  radicand,
  input  wire side_t             in_side,
  output logic                   valid,
  output logic [ROOT_W-1:0]      root,
  output side_t                  side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [ROOT_W-1:0] st_valid;
  logic [REM_W-1:0]  st_rem  [ROOT_W];
  logic [ROOT_W-1:0] st_root [ROOT_W];
  logic [RAD_W-1:0]  st_rad  [ROOT_W];
  side_t             st_side [ROOT_W];

  logic [REM_W-1:0]  rem_next  [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [RAD_W-1:0]  rad_next  [ROOT_W];

  // Each stage brings down the next two radicand bits and tries one root bit.
  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        root_in = '0;
        rad_in  = RAD_W'(radicand);
        rem_in  = REM_W'(rad_in[RAD_W-1 -: 2]);
      end else begin
        root_in = st_root[k-1];
        rad_in  = st_rad[k-1];
        rem_in  = {st_rem[k-1][REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      end
      trial = REM_W'({root_in, 2'b01});
      if (rem_in >= trial) begin
        rem_next[k]  = rem_in - trial;
        root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = rem_in;
        root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
      rad_next[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (en) begin
      st_valid <= {st_valid[ROOT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st_rem[k]  <= rem_next[k];
        st_root[k] <= root_next[k];
        st_rad[k]  <= rad_next[k];
        st_side[k] <= (k == 0) ? in_side : st_side[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign valid = st_valid[ROOT_W-1];
  assign root  = st_root[ROOT_W-1];
  assign side  = st_side[ROOT_W-1];

endmodule
`default_nettype wire

### rtl/bsd_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_out
// Final select, sign and saturation, then output register with skid stage.
// ----------------------------------------------------------------------------
module bsd_out import bsd_pkg::*; #(
  parameter  int DIMENSIONS = DIMENSIONS_DEFAULT,
  localparam int SUM_W      = SQ_W + $clog2(DIMENSIONS),
  localparam int ROOT_W     = (SUM_W + 1) / 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] root,
  input  wire side_t             side,
  input  wire logic              fluid_inside,
  output logic                   pipe_en,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output coord_t                 distance
);

  localparam logic signed [RES_W-1:0] LIMIT   = RES_W'(1) <<< (COORD_W - 1);
  localparam logic signed [RES_W-1:0] SAT_MAX = LIMIT - RES_W'(1);
  localparam logic signed [RES_W-1:0] SAT_MIN = -LIMIT;

  logic signed [RES_W-1:0] length;
  logic signed [RES_W-1:0] signed_res;
  coord_t                  res;
  logic                    skid_valid;
  coord_t                  skid_data;
  logic                    push;
  logic                    pop;

  always_comb begin
    if (side.too_long || ($signed(RES_W'(root)) > LIMIT)) length = LIMIT;
    else length = $signed(RES_W'(root));
    signed_res = side.any_pos ? length : RES_W'(side.largest);
    if (!fluid_inside) signed_res = -signed_res;
    if (signed_res > SAT_MAX) res = coord_t'(SAT_MAX);
    else if (signed_res < SAT_MIN) res = coord_t'(SAT_MIN);
    else res = signed_res[COORD_W-1:0];
  end

  assign pipe_en = !skid_valid;
  assign push    = in_valid && pipe_en;
  assign pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        distance   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) distance <= res;
      end
    end else if (!out_valid) begin
      out_valid <= push;
      if (push) distance <= res;
    end else if (push) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/box_signed_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_signed_distance_core
// Signed distance from a point to an axis-aligned box, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Takes one point per cycle and returns its signed distance to the configured
// box through 4 front stages, 32 root stages and 1 output register, one item
// per clock sustained while the pipeline is not frozen. Most of the depth
// comes from the square root, which resolves one result bit per pipeline
// stage. A stall on the output freezes the whole pipeline only once both the
// output register and its skid stage hold items, so items are still taken
// after out_ready drops until a result lands in the skid stage. Write the box
// corners and fluid_inside only while the pipeline is empty.
// ----------------------------------------------------------------------------
module box_signed_distance_core import bsd_pkg::*; #(
  parameter int DIMENSIONS    = DIMENSIONS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]     cfg_data,
  // point items
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire coord_t                 point_x,
  input  wire coord_t                 point_y,
  input  wire coord_t                 point_z,
  // distance items
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output coord_t                      distance
);

  localparam int SUM_W  = SQ_W + $clog2(DIMENSIONS);
  localparam int ROOT_W = (SUM_W + 1) / 2;

  coord_t low   [DIMENSIONS];
  coord_t high  [DIMENSIONS];
  logic   fluid_inside;
  coord_t point [DIMENSIONS];

  logic              pipe_en;
  logic              front_valid;
  logic [SUM_W-1:0]  front_sum;
  side_t             front_side;
  logic              root_valid;
  logic [ROOT_W-1:0] root;
  side_t             root_side;

  // Box registers: low corner, high corner per axis, then the sign flag.
  // Writes to axes beyond DIMENSIONS, or past the list, are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        low[i]  <= '0;
        high[i] <= coord_t'(COORD_W'(1) << FRACTION_BITS);
      end
      fluid_inside <= 1'b1;
    end else if (cfg_write) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        if (cfg_index == CFG_INDEX_W'(REG_LOW_X + i))  low[i]  <= $signed(cfg_data);
        if (cfg_index == CFG_INDEX_W'(REG_HIGH_X + i)) high[i] <= $signed(cfg_data);
      end
      if (cfg_index == REG_FLUID_INSIDE) fluid_inside <= cfg_data[0];
    end
  end

  // Gather the active axes; point_z is left out in two dimensions.
  assign point[0] = point_x;
  assign point[1] = point_y;
  if (DIMENSIONS > 2) begin : g_axis_z
    assign point[2] = point_z;
  end

  // The whole pipeline advances together; it holds only while the skid
  // stage is full.
  assign in_ready = pipe_en;

  bsd_front #(
    .DIMENSIONS (DIMENSIONS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (in_valid),
    .point    (point),
    .low      (low),
    .high     (high),
    .valid    (front_valid),
    .sum      (front_sum),
    .side     (front_side)
  );

  // Floor square root of the summed squares, exact to the result LSB.
  bsd_isqrt #(
    .DIMENSIONS (DIMENSIONS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (front_valid),
    .radicand (front_sum),
    .in_side  (front_side),
    .valid    (root_valid),
    .root     (root),
    .side     (root_side)
  );

  // Choose length or largest delta, apply the sign flag, saturate, buffer.
  bsd_out #(
    .DIMENSIONS (DIMENSIONS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (root_valid),
    .root         (root),
    .side         (root_side),
    .fluid_inside (fluid_inside),
    .pipe_en      (pipe_en),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance)
  );

endmodule
`default_nettype wire
